### src/texel_format_to_rgba8888_assert.svh
// Assertion macros shared by the texel format decoder modules.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef TEXEL_FORMAT_TO_RGBA8888_ASSERT_SVH
`define TEXEL_FORMAT_TO_RGBA8888_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tfr_pkg.sv
// Package of the texel format decoder: format and opcode codes, queue entry types
// and the channel widening and pixel decode functions. Depends on nothing.
`default_nettype none

package tfr_pkg;

   // Default palette depth and depth of the queue between front and back.
   localparam int PALETTE_DEPTH = 256;
   localparam int QUEUE_DEPTH   = 2;

   // Input item opcodes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_TEXEL = 1'b1;

   // Texel format register codes.
   localparam logic [3:0] FMT_RGBA16 = 4'd0;
   localparam logic [3:0] FMT_RGBA32 = 4'd1;
   localparam logic [3:0] FMT_CI4    = 4'd2;
   localparam logic [3:0] FMT_CI8    = 4'd3;
   localparam logic [3:0] FMT_I4     = 4'd4;
   localparam logic [3:0] FMT_I8     = 4'd5;
   localparam logic [3:0] FMT_IA4    = 4'd6;
   localparam logic [3:0] FMT_IA8    = 4'd7;
   localparam logic [3:0] FMT_IA16   = 4'd8;

   // How the back end turns a source word into a pixel.
   typedef enum logic [2:0] {
      KIND_5551 = 3'd0,
      KIND_RGBA = 3'd1,
      KIND_I4   = 3'd2,
      KIND_IA31 = 3'd3,
      KIND_I8   = 3'd4,
      KIND_IA44 = 3'd5,
      KIND_IA88 = 3'd6
   } kind_type;

   // One classified texel transfer. For two-pixel entries the first pixel's source
   // sits in the upper half of the word and the second pixel's in the lower half.
   typedef struct packed {
      kind_type    kind;
      logic        two;
      logic [31:0] word;
   } entry_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   // v*255/31, truncated: 8v plus floor(7v/31), the latter by reciprocal multiply.
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [7:0]  t;
      logic [15:0] p;
      t = {3'b000, v} * 8'd7;
      p = {8'h00, t} * 16'd265;
      return {v, 3'b000} + {5'b00000, p[15:13]};
   endfunction

   // v*255/7, truncated.
   function automatic logic [7:0] widen3(input logic [2:0] v);
      logic [7:0] r;
      unique case (v)
         3'd0: r = 8'd0;
         3'd1: r = 8'd36;
         3'd2: r = 8'd72;
         3'd3: r = 8'd109;
         3'd4: r = 8'd145;
         3'd5: r = 8'd182;
         3'd6: r = 8'd218;
         3'd7: r = 8'd255;
      endcase
      return r;
   endfunction

   // v*17 is the nibble repeated.
   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

   // Decode one pixel from the upper part of a source word (KIND_RGBA uses the whole word).
   function automatic pixel_type decode_pixel(input kind_type kind, input logic [31:0] src);
      pixel_type  p;
      logic [7:0] i;
      i = 8'h00;
      unique case (kind)
         KIND_5551: begin
            p.red   = widen5(src[31:27]);
            p.green = widen5(src[26:22]);
            p.blue  = widen5(src[21:17]);
            p.alpha = src[16] ? 8'hFF : 8'h00;
         end
         KIND_RGBA: begin
            p.red   = src[31:24];
            p.green = src[23:16];
            p.blue  = src[15:8];
            p.alpha = src[7:0];
         end
         KIND_I4: begin
            i = widen4(src[19:16]);
            p = '{i, i, i, 8'hFF};
         end
         KIND_IA31: begin
            i = widen3(src[19:17]);
            p = '{i, i, i, (src[16] ? 8'hFF : 8'h00)};
         end
         KIND_I8: begin
            p = '{src[31:24], src[31:24], src[31:24], 8'hFF};
         end
         KIND_IA44: begin
            i = widen4(src[31:28]);
            p = '{i, i, i, widen4(src[27:24])};
         end
         KIND_IA88: begin
            p = '{src[31:24], src[31:24], src[31:24], src[23:16]};
         end
         default: begin
            p = '0;
         end
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### src/texel_format_to_rgba8888.sv
// A texel transfer's first pixel is offered on rsp after it has passed the stage register,
// the queue and the result register, in that order.
// Throughput: one req transfer per cycle while the stage register can move on; nibble formats
// give two pixels that take turns in the single result register, so the queue fills and req stalls.
// Reset clears the format (rgba16), byte gathering, queue and valids; the palette
// memory is not cleared and an entry reads as undefined until it is loaded.
`default_nettype none

module texel_format_to_rgba8888 #(
   parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_enable,
   input  wire logic [3:0]   csr_write_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_opcode,
   input  wire logic [7:0]   req_source_byte,
   input  wire logic         req_start_of_image,
   input  wire logic         req_drop_low_nibble,
   input  wire logic [7:0]   req_palette_index,
   input  wire logic [15:0]  req_palette_entry,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic              rsp_last_of_run
);

   logic               push, queue_full, pop, head_valid;
   tfr_pkg::entry_type push_entry, head;

   // Front end: accepts transfers and classifies texels.
   tfr_front #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_source_byte     (req_source_byte),
      .req_start_of_image  (req_start_of_image),
      .req_drop_low_nibble (req_drop_low_nibble),
      .req_palette_index   (req_palette_index),
      .req_palette_entry   (req_palette_entry),
      .push                (push),
      .push_entry          (push_entry),
      .queue_full          (queue_full)
   );

   // Queue decoupling the two ends.
   tfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back end: expands entries into pixels.
   tfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

### src/tfr_front.sv
// Front end of the texel format decoder: format register, byte gathering,
// palette memory and the classifying stage register. Depends on tfr_pkg.
`default_nettype none

module tfr_front #(
   parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [3:0]          csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [7:0]          req_source_byte,
   input  wire logic                req_start_of_image,
   input  wire logic                req_drop_low_nibble,
   input  wire logic [7:0]          req_palette_index,
   input  wire logic [15:0]         req_palette_entry,
   output logic                     push,
   output tfr_pkg::entry_type       push_entry,
   input  wire logic                queue_full
);

   localparam int         AddrWidth  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [8:0] DepthLimit = 9'(PALETTE_DEPTH);

   logic [3:0]         texel_format_ff;
   logic [1:0]         byte_phase_ff, byte_phase_in, phase_eff;
   logic [23:0]        gathered_ff, gathered_in;
   logic               stage_valid_ff, stage_valid_in;
   tfr_pkg::entry_type stage_entry_ff, stage_entry_in;
   logic               stage_use_pal_ff, stage_use_pal_in;
   logic               accept, emit, write_en, read_en;
   logic [7:0]         idx0, idx1;
   logic [15:0]        palette_mem [PALETTE_DEPTH];
   logic [15:0]        rd0_ff, rd1_ff;
   logic               range0_ff, range1_ff;

   // A transfer is taken whenever the stage register is free or moves on this cycle.
   assign req_ready = !stage_valid_ff || !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = stage_valid_ff && !queue_full;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         texel_format_ff <= tfr_pkg::FMT_RGBA16;
      end else if (csr_write_enable) begin
         texel_format_ff <= csr_write_data;
      end
   end

   // Byte gathering and classification of a texel transfer.
   always_comb begin
      phase_eff        = req_start_of_image ? 2'd0 : byte_phase_ff;
      byte_phase_in    = byte_phase_ff;
      gathered_in      = gathered_ff;
      emit             = 1'b0;
      stage_entry_in   = '{tfr_pkg::KIND_I8, 1'b0, 32'h0};
      stage_use_pal_in = 1'b0;
      idx0             = req_source_byte;
      idx1             = {4'h0, req_source_byte[3:0]};
      if (accept && req_opcode == tfr_pkg::OP_TEXEL) begin
         unique case (texel_format_ff)
            tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_IA16: begin
               if (phase_eff == 2'd0) begin
                  gathered_in   = {gathered_ff[15:0], req_source_byte};
                  byte_phase_in = 2'd1;
               end else begin
                  byte_phase_in       = 2'd0;
                  emit                = 1'b1;
                  stage_entry_in.kind = (texel_format_ff == tfr_pkg::FMT_RGBA16) ?
                                        tfr_pkg::KIND_5551 : tfr_pkg::KIND_IA88;
                  stage_entry_in.word = {gathered_ff[7:0], req_source_byte, 16'h0};
               end
            end
            tfr_pkg::FMT_RGBA32: begin
               if (phase_eff != 2'd3) begin
                  gathered_in   = {gathered_ff[15:0], req_source_byte};
                  byte_phase_in = phase_eff + 2'd1;
               end else begin
                  byte_phase_in       = 2'd0;
                  emit                = 1'b1;
                  stage_entry_in.kind = tfr_pkg::KIND_RGBA;
                  stage_entry_in.word = {gathered_ff, req_source_byte};
               end
            end
            tfr_pkg::FMT_CI4, tfr_pkg::FMT_I4, tfr_pkg::FMT_IA4: begin
               byte_phase_in       = 2'd0;
               emit                = 1'b1;
               stage_entry_in.two  = !req_drop_low_nibble;
               stage_entry_in.word = {12'h0, req_source_byte[7:4],
                                      12'h0, req_source_byte[3:0]};
               idx0                = {4'h0, req_source_byte[7:4]};
               if (texel_format_ff == tfr_pkg::FMT_CI4) begin
                  stage_entry_in.kind = tfr_pkg::KIND_5551;
                  stage_use_pal_in    = 1'b1;
               end else if (texel_format_ff == tfr_pkg::FMT_I4) begin
                  stage_entry_in.kind = tfr_pkg::KIND_I4;
               end else begin
                  stage_entry_in.kind = tfr_pkg::KIND_IA31;
               end
            end
            tfr_pkg::FMT_CI8: begin
               byte_phase_in       = 2'd0;
               emit                = 1'b1;
               stage_entry_in.kind = tfr_pkg::KIND_5551;
               stage_use_pal_in    = 1'b1;
            end
            tfr_pkg::FMT_I8, tfr_pkg::FMT_IA8: begin
               byte_phase_in       = 2'd0;
               emit                = 1'b1;
               stage_entry_in.kind = (texel_format_ff == tfr_pkg::FMT_I8) ?
                                     tfr_pkg::KIND_I8 : tfr_pkg::KIND_IA44;
               stage_entry_in.word = {req_source_byte, 24'h0};
            end
            default: begin
               byte_phase_in = 2'd0;
            end
         endcase
      end
   end

   // Gathering state and stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff  <= 2'd0;
         gathered_ff    <= 24'h0;
         stage_valid_ff <= 1'b0;
      end else begin
         byte_phase_ff  <= byte_phase_in;
         gathered_ff    <= gathered_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign stage_valid_in = accept ? emit : (push ? 1'b0 : stage_valid_ff);

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_entry_ff   <= stage_entry_in;
         stage_use_pal_ff <= stage_use_pal_in;
      end
   end

   // Palette memory: loads write at transfer, texel transfers read at transfer so
   // that each lookup sees exactly the loads that came before it.
   assign write_en = accept && req_opcode == tfr_pkg::OP_LOAD &&
                     ({1'b0, req_palette_index} < DepthLimit);
   assign read_en  = accept && req_opcode == tfr_pkg::OP_TEXEL;

   always_ff @(posedge clock) begin
      if (write_en) begin
         palette_mem[req_palette_index[AddrWidth-1:0]] <= req_palette_entry;
      end
      if (read_en) begin
         rd0_ff    <= palette_mem[idx0[AddrWidth-1:0]];
         rd1_ff    <= palette_mem[idx1[AddrWidth-1:0]];
         range0_ff <= ({1'b0, idx0} < DepthLimit);
         range1_ff <= ({1'b0, idx1} < DepthLimit);
      end
   end

   // Entry handed to the queue; palette colours out of range read as zero.
   always_comb begin
      push_entry = stage_entry_ff;
      if (stage_use_pal_ff) begin
         push_entry.word = {(range0_ff ? rd0_ff : 16'h0), (range1_ff ? rd1_ff : 16'h0)};
      end
   end

endmodule

`default_nettype wire

### src/tfr_queue.sv
// Short queue between the front and back ends of the texel format decoder.
// Depends on tfr_pkg and the shared assertion macros.
`default_nettype none
`include "texel_format_to_rgba8888_assert.svh"

module tfr_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tfr_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output tfr_pkg::entry_type       head
);

   localparam int Depth      = tfr_pkg::QUEUE_DEPTH;
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   tfr_pkg::entry_type          entries_ff [Depth];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]       count_ff, count_in;

   assign full       = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The front must never overrun the queue, nor the back drain an empty one.
   `TFR_ASSERT_SAME(a_no_overrun, clock, reset, push, !full, "queue written while full")
   `TFR_ASSERT_SAME(a_no_underrun, clock, reset, pop, head_valid, "queue read while empty")

endmodule

`default_nettype wire

### src/tfr_back.sv
// Back end of the texel format decoder: expands queue entries into one or two
// pixels and holds them in the result register. Depends on tfr_pkg and the macros.
`default_nettype none
`include "texel_format_to_rgba8888_assert.svh"

module tfr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire tfr_pkg::entry_type  head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue,
   output logic [7:0]               rsp_alpha,
   output logic                     rsp_last_of_run
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                second_ff, second_in;
   tfr_pkg::pixel_type  pixel_ff, pixel_in;
   logic                last_ff, last_in;
   logic                advance;
   logic [31:0]         src;

   // A pixel moves into the result register when it is empty or being taken.
   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last_in = !head.two || second_ff;
   assign pop     = advance && last_in;

   // The second pixel of a nibble pair comes from the lower half of the word.
   assign src      = second_ff ? {head.word[15:0], 16'h0} : head.word;
   assign pixel_in = tfr_pkg::decode_pixel(head.kind, src);

   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign second_in    = advance ? !last_in : second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = pixel_ff.red;
   assign rsp_green       = pixel_ff.green;
   assign rsp_blue        = pixel_ff.blue;
   assign rsp_alpha       = pixel_ff.alpha;
   assign rsp_last_of_run = last_ff;

   // While the second pixel is pending, its pair must still be at the queue head,
   // and the first pixel of a pair never carries the last-of-run mark.
   `TFR_ASSERT_SAME(a_pair_held, clock, reset, second_ff, head_valid && head.two,
      "second pixel pending without a pair at the queue head")
   `TFR_ASSERT_NEXT(a_first_not_last, clock, reset, advance && !last_in,
      second_ff && rsp_valid && !rsp_last_of_run, "first pixel of a pair marked last")

endmodule

`default_nettype wire

### verif/tfr_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the texel format decoder: watches the request, response and register ports,
// predicts every decoded pixel from the accepted transfers and compares the pixels that come out.
// Depends on tfr_pkg for the opcode and format codes and the default palette depth.

module tfr_pixel_checker #(
   parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_source_byte,
   input  logic        req_start_of_image,
   input  logic        req_drop_low_nibble,
   input  logic [7:0]  req_palette_index,
   input  logic [15:0] req_palette_entry,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha,
   input  logic        rsp_last_of_run,
   output int          error_count,
   output int          pixels_outstanding
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_of_run;
   } pixel_rec_type;

   // Shadow of the decoder state.
   logic [3:0]  format_reg;
   logic [1:0]  gather_phase;
   logic [23:0] gathered;
   logic [15:0] palette_copy [0:PALETTE_DEPTH-1];

   pixel_rec_type expected_pixels[$];
   int            mismatches = 0;

   // Channel widening, truncating.
   function automatic logic [7:0] scale5(input logic [4:0] v);
      int product;
      product = (int'(v) * 255) / 31;
      return product[7:0];
   endfunction

   function automatic logic [7:0] scale3(input logic [2:0] v);
      int product;
      product = (int'(v) * 255) / 7;
      return product[7:0];
   endfunction

   function automatic logic [7:0] scale4(input logic [3:0] v);
      int product;
      product = int'(v) * 17;
      return product[7:0];
   endfunction

   function automatic pixel_rec_type make_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [7:0] a,
                                                input logic last);
      pixel_rec_type p;
      p = '{r, g, b, a, last};
      return p;
   endfunction

   function automatic pixel_rec_type colour_5551(input logic [15:0] c, input logic last);
      return make_pixel(scale5(c[15:11]), scale5(c[10:6]), scale5(c[5:1]),
                        c[0] ? 8'hFF : 8'h00, last);
   endfunction

   // Entries beyond the palette depth read as colour zero.
   function automatic logic [15:0] palette_entry_at(input logic [7:0] idx);
      if (int'(idx) >= PALETTE_DEPTH) return 16'h0000;
      return palette_copy[idx];
   endfunction

   // One pixel from a four-bit texel, in the current nibble format.
   function automatic pixel_rec_type nibble_pixel(input logic [3:0] n, input logic last);
      logic [7:0] level;
      if (format_reg == tfr_pkg::FMT_CI4)
         return colour_5551(palette_entry_at({4'h0, n}), last);
      if (format_reg == tfr_pkg::FMT_I4) begin
         level = scale4(n);
         return make_pixel(level, level, level, 8'hFF, last);
      end
      level = scale3(n[3:1]);
      return make_pixel(level, level, level, n[0] ? 8'hFF : 8'h00, last);
   endfunction

   // Decode one texture byte, queueing the pixels that it gives.
   task automatic decode_texture_byte(input logic [7:0] b, input logic soi, input logic drop);
      logic [7:0] hi;
      logic [7:0] level;
      if (soi) gather_phase = 2'd0;
      case (format_reg)
         tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_IA16: begin
            if (gather_phase == 2'd0) begin
               gathered     = {gathered[15:0], b};
               gather_phase = 2'd1;
            end else begin
               hi           = gathered[7:0];
               gather_phase = 2'd0;
               if (format_reg == tfr_pkg::FMT_RGBA16)
                  expected_pixels.push_back(colour_5551({hi, b}, 1'b1));
               else
                  expected_pixels.push_back(make_pixel(hi, hi, hi, b, 1'b1));
            end
         end
         tfr_pkg::FMT_RGBA32: begin
            if (gather_phase != 2'd3) begin
               gathered     = {gathered[15:0], b};
               gather_phase = gather_phase + 2'd1;
            end else begin
               gather_phase = 2'd0;
               expected_pixels.push_back(make_pixel(gathered[23:16], gathered[15:8],
                                                    gathered[7:0], b, 1'b1));
            end
         end
         tfr_pkg::FMT_CI4, tfr_pkg::FMT_I4, tfr_pkg::FMT_IA4: begin
            gather_phase = 2'd0;
            if (drop) begin
               expected_pixels.push_back(nibble_pixel(b[7:4], 1'b1));
            end else begin
               expected_pixels.push_back(nibble_pixel(b[7:4], 1'b0));
               expected_pixels.push_back(nibble_pixel(b[3:0], 1'b1));
            end
         end
         tfr_pkg::FMT_CI8: begin
            gather_phase = 2'd0;
            expected_pixels.push_back(colour_5551(palette_entry_at(b), 1'b1));
         end
         tfr_pkg::FMT_I8: begin
            gather_phase = 2'd0;
            expected_pixels.push_back(make_pixel(b, b, b, 8'hFF, 1'b1));
         end
         tfr_pkg::FMT_IA8: begin
            gather_phase = 2'd0;
            level        = scale4(b[7:4]);
            expected_pixels.push_back(make_pixel(level, level, level, scale4(b[3:0]), 1'b1));
         end
         default: begin
            // Unused formats drop the byte and restart gathering.
            gather_phase = 2'd0;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Track every transfer at the clock edge; prediction comes before comparison so that a
   // pixel transfer in the same cycle still finds its expectation.
   always @(posedge clock) begin
      pixel_rec_type want;
      if (reset) begin
         format_reg   = tfr_pkg::FMT_RGBA16;
         gather_phase = 2'd0;
         gathered     = 24'h000000;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) format_reg = csr_write_data;
         if (req_valid && req_ready) begin
            if (req_opcode == tfr_pkg::OP_LOAD) begin
               if (int'(req_palette_index) < PALETTE_DEPTH)
                  palette_copy[req_palette_index] = req_palette_entry;
            end else begin
               decode_texture_byte(req_source_byte, req_start_of_image, req_drop_low_nibble);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel transfer with no expected pixel waiting");
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("alpha", want.alpha, rsp_alpha);
               check_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, rsp_last_of_run});
            end
         end
      end
      pixels_outstanding <= expected_pixels.size();
      error_count        <= mismatches;
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the texel format decoder testbench: clock, reset, register writes and request and
// response traffic with random idling. Depends on tfr_pkg, the decoder and tfr_pixel_checker.

module tb_top;

   localparam int TIMEOUT_CYCLES = 200000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_ITEMS    = 140;
   localparam int HOLD_PHASE     = 2;
   localparam int HOLD_CYCLES    = 300;
   localparam int QUIET_START    = 2500;
   localparam int QUIET_END      = 3300;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        csr_write_enable    = 1'b0;
   logic [3:0]  csr_write_data      = tfr_pkg::FMT_RGBA16;
   logic        req_valid           = 1'b0;
   logic        req_opcode          = tfr_pkg::OP_TEXEL;
   logic [7:0]  req_source_byte     = 8'h00;
   logic        req_start_of_image  = 1'b0;
   logic        req_drop_low_nibble = 1'b0;
   logic [7:0]  req_palette_index   = 8'h00;
   logic [15:0] req_palette_entry   = 16'h0000;
   logic        rsp_ready           = 1'b0;

   wire         req_ready;
   wire         rsp_valid;
   wire  [7:0]  rsp_red;
   wire  [7:0]  rsp_green;
   wire  [7:0]  rsp_blue;
   wire  [7:0]  rsp_alpha;
   wire         rsp_last_of_run;

   int          error_count;
   int          pixels_outstanding;

   // Palette entries that have been loaded; lookups only ever hit these.
   bit          palette_written [0:255];
   bit          gaps_enabled = 1'b1;
   // Set while the phase runs in which the receiver holds off once.
   bit          hold_armed   = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   texel_format_to_rgba8888 dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_source_byte     (req_source_byte),
      .req_start_of_image  (req_start_of_image),
      .req_drop_low_nibble (req_drop_low_nibble),
      .req_palette_index   (req_palette_index),
      .req_palette_entry   (req_palette_entry),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_alpha           (rsp_alpha),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   tfr_pixel_checker pixel_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_source_byte     (req_source_byte),
      .req_start_of_image  (req_start_of_image),
      .req_drop_low_nibble (req_drop_low_nibble),
      .req_palette_index   (req_palette_index),
      .req_palette_entry   (req_palette_entry),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_alpha           (rsp_alpha),
      .rsp_last_of_run     (rsp_last_of_run),
      .error_count         (error_count),
      .pixels_outstanding  (pixels_outstanding)
   );

   // Offer one item and return at the edge where its transfer happens.
   task automatic send_item(input logic op, input logic [7:0] b, input logic soi,
                            input logic drop, input logic [7:0] pidx, input logic [15:0] pent);
      if (gaps_enabled && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_source_byte     <= b;
      req_start_of_image  <= soi;
      req_drop_low_nibble <= drop;
      req_palette_index   <= pidx;
      req_palette_entry   <= pent;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_texel(input logic [7:0] b, input logic soi, input logic drop);
      send_item(tfr_pkg::OP_TEXEL, b, soi, drop, 8'($urandom_range(255)),
                16'($urandom_range(65535)));
   endtask

   task automatic send_load(input logic [7:0] idx, input logic [15:0] colour);
      palette_written[idx] = 1'b1;
      send_item(tfr_pkg::OP_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), idx, colour);
   endtask

   // Stop offering and wait until every expected pixel has arrived and the pipe has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_format(input logic [3:0] fmt);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= fmt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly texture bytes with random content, with the odd load and restart mixed in.
   task automatic random_item(input logic [3:0] fmt);
      logic [7:0] b;
      if ($urandom_range(99) < 8) begin
         send_load(8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else begin
         b = 8'($urandom_range(255));
         if (fmt == tfr_pkg::FMT_CI8)
            while (!palette_written[b]) b = 8'($urandom_range(255));
         send_texel(b, $urandom_range(99) < 8, $urandom_range(3) == 0);
      end
   endtask

   task automatic random_phase(input logic [3:0] fmt, input int items, input bit hold);
      set_format(fmt);
      hold_armed = hold;
      if (fmt == tfr_pkg::FMT_CI4)
         for (int i = 0; i < 16; i++) send_load(8'(i), 16'($urandom_range(65535)));
      if (fmt == tfr_pkg::FMT_CI8)
         repeat (32) send_load(8'($urandom_range(255)), 16'($urandom_range(65535)));
      repeat (items) random_item(fmt);
   endtask

   // Receiver: random stalls, one long hold-off while items keep coming and one stretch
   // that never stalls.
   initial begin
      int rx_cycle;
      bit hold_done;
      rx_cycle  = 0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (hold_armed && !hold_done && req_valid) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_cycle += HOLD_CYCLES;
         end else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 9);
         end
      end
   end

   // Guard against a hung run.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int         order [0:8];
      int         j;
      int         tmp;
      logic [3:0] phase_fmt;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two-byte colour in the format left by reset: extremes, then a restart mid-texel.
      send_texel(8'h00, 1'b1, 1'b0);
      send_texel(8'h00, 1'b0, 1'b0);
      send_texel(8'hFF, 1'b0, 1'b0);
      send_texel(8'hFF, 1'b0, 1'b0);
      send_texel(8'h12, 1'b1, 1'b0);
      send_texel(8'h80, 1'b1, 1'b0);
      send_texel(8'h01, 1'b0, 1'b0);

      set_format(tfr_pkg::FMT_RGBA32);
      send_texel(8'hFF, 1'b1, 1'b0);
      send_texel(8'h00, 1'b0, 1'b0);
      send_texel(8'h80, 1'b0, 1'b0);
      send_texel(8'h01, 1'b0, 1'b0);

      // Palette nibbles: both pixels, then the low nibble dropped.
      set_format(tfr_pkg::FMT_CI4);
      send_load(8'd0, 16'h0000);
      send_load(8'd15, 16'hFFFF);
      send_texel(8'hF0, 1'b1, 1'b0);
      send_texel(8'h0F, 1'b0, 1'b1);

      // The drop flag has no effect outside the nibble formats.
      set_format(tfr_pkg::FMT_CI8);
      send_load(8'd255, 16'h8001);
      send_texel(8'hFF, 1'b0, 1'b0);
      send_texel(8'h00, 1'b0, 1'b1);

      set_format(tfr_pkg::FMT_I4);
      send_texel(8'hF0, 1'b0, 1'b0);
      send_texel(8'h0F, 1'b0, 1'b1);

      set_format(tfr_pkg::FMT_I8);
      send_texel(8'h00, 1'b0, 1'b0);
      send_texel(8'hFF, 1'b0, 1'b0);

      set_format(tfr_pkg::FMT_IA4);
      send_texel(8'h1E, 1'b0, 1'b0);
      send_texel(8'hF1, 1'b0, 1'b1);

      set_format(tfr_pkg::FMT_IA8);
      send_texel(8'hF0, 1'b0, 1'b0);

      set_format(tfr_pkg::FMT_IA16);
      send_texel(8'hFF, 1'b1, 1'b0);
      send_texel(8'h00, 1'b0, 1'b0);

      // An unused format swallows bytes and restarts gathering.
      set_format(4'd15);
      send_texel(8'h55, 1'b1, 1'b0);
      send_texel(8'hAA, 1'b0, 1'b0);

      // Random phases: every format once in shuffled order, then a random mix with one unused format.
      for (int i = 0; i < 9; i++) order[i] = i;
      for (int i = 8; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int p = 0; p < 15; p++) begin
         gaps_enabled = (p != 4);
         if (p == 11) begin
            random_phase(4'($urandom_range(15, 9)), 20, 1'b0);
         end else begin
            phase_fmt = (p < 9) ? 4'(order[p]) : 4'($urandom_range(8));
            random_phase(phase_fmt, PHASE_ITEMS, p == HOLD_PHASE);
         end
      end
      gaps_enabled = 1'b1;

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
